// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, character codes, command encoding and queue entry type for
// the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CELL_W      = 11;
    localparam int BYTE_W      = 8;
    localparam int CELL_DATA_W = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CELL_DATA_W-1:0] BLANK_CELL = 16'h0720;

    localparam logic [BYTE_W-1:0] CH_ESC   = 8'hFF;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h01;
    localparam logic [BYTE_W-1:0] CH_UP    = 8'h02;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] ATTR_OFF = 8'hFF;

    typedef enum logic [2:0] {
        OP_READ,
        OP_CHAR,
        OP_ESC,
        OP_CR,
        OP_LF,
        OP_BS,
        OP_RIGHT,
        OP_UP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_string;
        logic [CELL_W-1:0] cell_index;
        logic              in_range;
    } cmd_t;

endpackage

// ===== rtl/tcw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tcw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Input side: accepts transactions, decodes each byte into a command and
// holds commands in a short queue for the engine.
// ----------------------------------------------------------------------------
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic [tcw_pkg::BYTE_W-1:0]  text_byte,
    input  logic                        end_of_string,
    input  logic [tcw_pkg::CELL_W-1:0]  cell_index,
    input  logic                        clearing,
    output logic                        q_valid,
    output tcw_pkg::cmd_t               q_cmd,
    input  logic                        q_pop
);

    localparam int N    = COLUMNS * ROWS;
    localparam int PTRW = (tcw_pkg::QUEUE_DEPTH > 1) ? $clog2(tcw_pkg::QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(tcw_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTRW-1:0] PTR_LAST = PTRW'(tcw_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNTW-1:0] CNT_FULL = CNTW'(tcw_pkg::QUEUE_DEPTH);

    tcw_pkg::cmd_t   entry_reg [tcw_pkg::QUEUE_DEPTH];
    logic [PTRW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg,  count_next;
    tcw_pkg::cmd_t   cmd_in;
    logic            push;

    always_comb
    begin
        cmd_in.text_byte     = text_byte;
        cmd_in.end_of_string = end_of_string;
        cmd_in.cell_index    = cell_index;
        cmd_in.in_range      = (32'(cell_index) < 32'(N));
        if (action)
        begin
            cmd_in.op = tcw_pkg::OP_READ;
        end
        else
        begin
            case (text_byte)
                tcw_pkg::CH_ESC:   cmd_in.op = tcw_pkg::OP_ESC;
                tcw_pkg::CH_CR:    cmd_in.op = tcw_pkg::OP_CR;
                tcw_pkg::CH_LF:    cmd_in.op = tcw_pkg::OP_LF;
                tcw_pkg::CH_BS:    cmd_in.op = tcw_pkg::OP_BS;
                tcw_pkg::CH_RIGHT: cmd_in.op = tcw_pkg::OP_RIGHT;
                tcw_pkg::CH_UP:    cmd_in.op = tcw_pkg::OP_UP;
                default:           cmd_in.op = tcw_pkg::OP_CHAR;
            endcase
        end
    end

    assign in_stall = (count_reg == CNT_FULL) || clearing;
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== rtl/tcw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back
// Console engine: owns the screen RAM, cursor and attribute state, executes
// queued commands, scrolls by copying the screen up one row, and holds the
// result register.
// ----------------------------------------------------------------------------
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  tcw_pkg::cmd_t               q_cmd,
    output logic                        q_pop,
    output logic                        clearing,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tcw_pkg::CELL_W-1:0]  cursor_cell,
    output logic [tcw_pkg::BYTE_W-1:0]  read_char,
    output logic [tcw_pkg::BYTE_W-1:0]  read_attr,
    output logic                        scrolled,
    output logic                        skipping
);

    localparam int N    = COLUMNS * ROWS;
    localparam int AW   = $clog2(N);
    localparam int CURW = $clog2(N + COLUMNS);
    localparam int COLW = $clog2(COLUMNS);
    localparam int DW   = tcw_pkg::CELL_DATA_W;
    localparam int BW   = tcw_pkg::BYTE_W;

    localparam logic [CURW-1:0] COLS_C   = CURW'(COLUMNS);
    localparam logic [CURW-1:0] N_C      = CURW'(N);
    localparam logic [COLW-1:0] COL_LAST = COLW'(COLUMNS - 1);
    localparam logic [AW-1:0]   A_LAST   = AW'(N - 1);
    localparam logic [AW-1:0]   A_COLS   = AW'(COLUMNS);
    localparam logic [AW-1:0]   A_FILL0  = AW'(N - COLUMNS);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_COPY  = 5'b01000,
        S_FILL  = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    tcw_pkg::cmd_t   cmd_reg, cmd_next;
    logic [CURW-1:0] cursor_reg, cursor_next;
    logic [COLW-1:0] col_reg, col_next;
    logic [BW-1:0]   attr_reg, attr_next;
    logic            attr_on_reg, attr_on_next;
    logic            attr_pend_reg, attr_pend_next;
    logic            nul_reg, nul_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   src_reg, src_next;
    logic [AW-1:0]   wa_reg, wa_next;
    logic            wr_pend_reg, wr_pend_next;
    logic            out_valid_reg, out_valid_next;

    logic [tcw_pkg::CELL_W-1:0] cursor_cell_reg, cursor_cell_next;
    logic [BW-1:0]              read_char_reg, read_char_next;
    logic [BW-1:0]              read_attr_reg, read_attr_next;
    logic                       scrolled_reg, scrolled_next;
    logic                       skipping_reg, skipping_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [DW-1:0]   ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [DW-1:0]   ram_rdata;

    logic [CURW-1:0] cur_mv;
    logic [COLW-1:0] col_mv;
    logic            scr;
    logic [BW-1:0]   hi_byte;

    tcw_ram #(
        .WIDTH (DW),
        .DEPTH (N)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign clearing = (state_reg == S_CLEAR);
    assign hi_byte  = attr_on_reg ? attr_reg : ram_rdata[DW-1:BW];

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        cursor_next      = cursor_reg;
        col_next         = col_reg;
        attr_next        = attr_reg;
        attr_on_next     = attr_on_reg;
        attr_pend_next   = attr_pend_reg;
        nul_next         = nul_reg;
        cnt_next         = cnt_reg;
        src_next         = src_reg;
        wa_next          = wa_reg;
        wr_pend_next     = 1'b0;
        out_valid_next   = out_valid_reg && out_stall;
        cursor_cell_next = cursor_cell_reg;
        read_char_next   = read_char_reg;
        read_attr_next   = read_attr_reg;
        scrolled_next    = scrolled_reg;
        skipping_next    = skipping_reg;
        ram_we           = 1'b0;
        ram_waddr        = cnt_reg;
        ram_wdata        = tcw_pkg::BLANK_CELL;
        ram_raddr        = src_reg;
        q_pop            = 1'b0;
        cur_mv           = cursor_reg;
        col_mv           = col_reg;
        scr              = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                if (cnt_reg == A_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (q_valid && (!out_valid_reg || !out_stall))
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = S_EXEC;
                    ram_raddr  = (q_cmd.op == tcw_pkg::OP_READ) ? AW'(q_cmd.cell_index)
                                                                : AW'(cursor_reg);
                end
            end

            S_EXEC:
            begin
                read_char_next = '0;
                read_attr_next = '0;
                if (cmd_reg.op == tcw_pkg::OP_READ)
                begin
                    if (cmd_reg.in_range)
                    begin
                        read_char_next = ram_rdata[BW-1:0];
                        read_attr_next = ram_rdata[DW-1:BW];
                    end
                end
                else if (!nul_reg)
                begin
                    if (attr_pend_reg)
                    begin
                        attr_next      = cmd_reg.text_byte;
                        attr_on_next   = (cmd_reg.text_byte != tcw_pkg::ATTR_OFF);
                        attr_pend_next = 1'b0;
                    end
                    else
                    begin
                        case (cmd_reg.op)
                            tcw_pkg::OP_ESC:
                            begin
                                attr_pend_next = 1'b1;
                            end
                            tcw_pkg::OP_CR:
                            begin
                                cur_mv = cursor_reg - CURW'(col_reg);
                                col_mv = '0;
                            end
                            tcw_pkg::OP_LF:
                            begin
                                cur_mv = cursor_reg + COLS_C;
                            end
                            tcw_pkg::OP_BS:
                            begin
                                if (cursor_reg != '0)
                                begin
                                    cur_mv = cursor_reg - 1'b1;
                                    col_mv = (col_reg == '0) ? COL_LAST : col_reg - 1'b1;
                                end
                            end
                            tcw_pkg::OP_RIGHT:
                            begin
                                cur_mv = cursor_reg + 1'b1;
                                col_mv = (col_reg == COL_LAST) ? '0 : col_reg + 1'b1;
                            end
                            tcw_pkg::OP_UP:
                            begin
                                if (cursor_reg >= COLS_C)
                                begin
                                    cur_mv = cursor_reg - COLS_C;
                                end
                                else
                                begin
                                    cur_mv = '0;
                                    col_mv = '0;
                                end
                            end
                            tcw_pkg::OP_CHAR:
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(cursor_reg);
                                ram_wdata = {hi_byte, cmd_reg.text_byte};
                                cur_mv    = cursor_reg + 1'b1;
                                col_mv    = (col_reg == COL_LAST) ? '0 : col_reg + 1'b1;
                                if (cmd_reg.text_byte == tcw_pkg::CH_NUL)
                                begin
                                    nul_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                cur_mv = cursor_reg;
                            end
                        endcase
                        if (cur_mv >= N_C)
                        begin
                            cur_mv = cur_mv - COLS_C;
                            scr    = 1'b1;
                        end
                    end
                end
                if (cmd_reg.op != tcw_pkg::OP_READ && cmd_reg.end_of_string)
                begin
                    nul_next       = 1'b0;
                    attr_pend_next = 1'b0;
                end
                cursor_next      = cur_mv;
                col_next         = col_mv;
                cursor_cell_next = tcw_pkg::CELL_W'(cur_mv);
                scrolled_next    = scr;
                skipping_next    = nul_next;
                src_next         = A_COLS;
                out_valid_next   = !scr;
                state_next       = scr ? S_COPY : S_IDLE;
            end

            // one row up: read cell i+COLUMNS, write it to cell i in the following cycle
            S_COPY:
            begin
                ram_raddr    = src_reg;
                ram_we       = wr_pend_reg;
                ram_waddr    = wa_reg;
                ram_wdata    = ram_rdata;
                wr_pend_next = 1'b1;
                wa_next      = src_reg - A_COLS;
                if (src_reg == A_LAST)
                begin
                    cnt_next   = A_FILL0;
                    state_next = S_FILL;
                end
                else
                begin
                    src_next = src_reg + 1'b1;
                end
            end

            S_FILL:
            begin
                ram_we = 1'b1;
                if (wr_pend_reg)
                begin
                    ram_waddr = wa_reg;
                    ram_wdata = ram_rdata;
                end
                else if (cnt_reg == A_LAST)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cursor_reg    <= '0;
            col_reg       <= '0;
            attr_reg      <= '0;
            attr_on_reg   <= 1'b0;
            attr_pend_reg <= 1'b0;
            nul_reg       <= 1'b0;
            cnt_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            attr_reg      <= attr_next;
            attr_on_reg   <= attr_on_next;
            attr_pend_reg <= attr_pend_next;
            nul_reg       <= nul_next;
            cnt_reg       <= cnt_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        src_reg         <= src_next;
        wa_reg          <= wa_next;
        cursor_cell_reg <= cursor_cell_next;
        read_char_reg   <= read_char_next;
        read_attr_reg   <= read_attr_next;
        scrolled_reg    <= scrolled_next;
        skipping_reg    <= skipping_next;
    end

    assign out_valid   = out_valid_reg;
    assign cursor_cell = cursor_cell_reg;
    assign read_char   = read_char_reg;
    assign read_attr   = read_attr_reg;
    assign scrolled    = scrolled_reg;
    assign skipping    = skipping_reg;

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC || state_reg == S_FILL))
        else $error("result raised outside execute or fill");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_reg < N_C) && (col_reg <= COL_LAST))
        else $error("cursor out of screen");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE))
        else $error("command taken while engine busy");

    a_copy_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> (state_reg == S_COPY || state_reg == S_FILL))
        else $error("scroll write pending outside scroll");

    a_scroll_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL && state_next == S_IDLE) |=> (out_valid_reg && scrolled_reg))
        else $error("scroll finished without a scrolled result");

endmodule

// ===== rtl/text_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: screen of character/attribute cells, cursor control,
// attribute escapes, scrolling and cell readback.
// ----------------------------------------------------------------------------
// After reset the screen RAM is cleared to blank cells one cell per cycle, and
// in_stall stays high until the clear is done. Each text or read transaction
// is then handled by the engine as a command pop with cell read, then an
// execute step, and a queue of two entries sits between the input and the
// engine. A byte that moves the cursor past the last cell triggers a scroll
// through the single-write-port screen RAM: the screen is copied up one row,
// then the last row is filled with blank cells, before its result appears. A
// new transaction enters the engine only when the result register is empty or
// being emptied.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic [tcw_pkg::BYTE_W-1:0]  text_byte,
    input  logic                        end_of_string,
    input  logic [tcw_pkg::CELL_W-1:0]  cell_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tcw_pkg::CELL_W-1:0]  cursor_cell,
    output logic [tcw_pkg::BYTE_W-1:0]  read_char,
    output logic [tcw_pkg::BYTE_W-1:0]  read_attr,
    output logic                        scrolled,
    output logic                        skipping
);

    logic          q_valid;
    tcw_pkg::cmd_t q_cmd;
    logic          q_pop;
    logic          clearing;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .text_byte     (text_byte),
        .end_of_string (end_of_string),
        .cell_index    (cell_index),
        .clearing      (clearing),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cursor_cell (cursor_cell),
        .read_char   (read_char),
        .read_attr   (read_attr),
        .scrolled    (scrolled),
        .skipping    (skipping)
    );

endmodule
